[sv/frqs_pkg.sv]
// Shared types, codes and constants of the FIFO run-queue scheduler.
`timescale 1ns / 1ps
`default_nettype none

package frqs_pkg;

   localparam int ID_W            = 6;
   localparam int CPU_W           = 3;
   localparam int QCNT_W          = 7;
   localparam int TICK_W          = 16;
   localparam int DEF_MAX_THREADS = 64;
   localparam int DEF_NUM_CPUS    = 8;

   localparam logic [TICK_W-1:0] TICK_INTERVAL_RESET = TICK_W'(10);

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;
   localparam logic [1:0] OP_YIELD  = 2'd3;

   localparam logic [1:0] ERR_OK         = 2'd0;
   localparam logic [1:0] ERR_DUP_ADD    = 2'd1;
   localparam logic [1:0] ERR_NOT_QUEUED = 2'd2;

   typedef struct packed {
      logic [1:0]       opcode;
      logic [ID_W-1:0]  thread_id;
      logic [CPU_W-1:0] cpu_index;
      logic             prev_runnable;
   } req_type;

   typedef struct packed {
      logic              switched;
      logic              prev_valid;
      logic [ID_W-1:0]   prev_thread;
      logic              next_is_idle;
      logic [ID_W-1:0]   next_thread;
      logic [QCNT_W-1:0] queue_count;
      logic [1:0]        error_code;
   } rsp_type;

   // What a CPU runs: a real thread, its idle thread, or nothing yet.
   typedef struct packed {
      logic            real_thread;
      logic            idle_thread;
      logic [ID_W-1:0] id;
   } run_type;

   typedef struct packed {
      logic accept;
      logic fetch;
      logic apply;
      logic requeue;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic requeue;
   } status_type;

endpackage

`default_nettype wire

[sv/frqs_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module frqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/frqs_ctrl.sv]
// Sequencing state machine of the run-queue scheduler.
`timescale 1ns / 1ps
`default_nettype none

module frqs_ctrl
   import frqs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire status_type status,
   output cmd_type         cmd,
   output logic            busy
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_FETCH   = 2'd1;
   localparam logic [1:0] ST_APPLY   = 2'd2;
   localparam logic [1:0] ST_REQUEUE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            state_in = status.requeue ? ST_REQUEUE : ST_IDLE;
         end
         ST_REQUEUE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd.accept  = (state_ff == ST_IDLE) && start;
   assign cmd.fetch   = (state_ff == ST_FETCH);
   assign cmd.apply   = (state_ff == ST_APPLY);
   assign cmd.requeue = (state_ff == ST_REQUEUE);
   assign cmd.finish  = ((state_ff == ST_APPLY) && !status.requeue) ||
                        (state_ff == ST_REQUEUE);
   assign busy        = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

[sv/frqs_datapath.sv]
// Run-queue state, link memories and schedule decision logic.
`timescale 1ns / 1ps
`default_nettype none

module frqs_datapath
   import frqs_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_THREADS,
   parameter int NCPU  = DEF_NUM_CPUS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire req_type           req_data,
   input  wire cmd_type           cmd,
   input  wire logic              csr_wr_en,
   input  wire logic [TICK_W-1:0] csr_wr_data,
   output status_type             status,
   output logic                   rsp_strobe,
   output rsp_type                rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = (NCPU > 1) ? $clog2(NCPU) : 1;
   localparam logic [ID_W:0]  DEPTH_LIM = (ID_W + 1)'(DEPTH);
   localparam logic [CPU_W:0] CPU_LIM   = (CPU_W + 1)'(NCPU);

   req_type             req_ff, req_in;
   logic [ID_W-1:0]     head_ff, head_in;
   logic [ID_W-1:0]     tail_ff, tail_in;
   logic [QCNT_W-1:0]   total_ff, total_in;
   logic [TICK_W-1:0]   phase_ff, phase_in;
   logic [TICK_W-1:0]   interval_ff, interval_in;
   logic [DEPTH-1:0]    inq_ff, inq_in;
   run_type             running_ff [NCPU];
   run_type             running_in [NCPU];
   logic [ID_W-1:0]     reid_ff, reid_in;
   rsp_type             pend_ff, pend_in;
   rsp_type             rsp_ff, rsp_in;
   logic                strobe_ff, strobe_in;

   logic                nl_we, pl_we;
   logic [AW-1:0]       nl_addr, pl_addr;
   logic [ID_W-1:0]     nl_data, pl_data;
   logic [ID_W-1:0]     rd_next, rd_prev;

   logic                tid_ok, tid_inq, cpu_ok, tick_fire, sched, have;
   logic                do_switch, prev_ok, requeue, unlink_en, add_en, app_en;
   logic [AW-1:0]       taddr;
   logic [CW-1:0]       cidx;
   logic [TICK_W-1:0]   phase_inc;
   logic [ID_W-1:0]     unlink_id, app_id;
   run_type             cur, nxt;

   frqs_ram #(.WIDTH(ID_W), .DEPTH(DEPTH)) u_next_link (
      .clock   (clock),
      .wr_en   (nl_we),
      .wr_addr (nl_addr),
      .wr_data (nl_data),
      .rd_en   (cmd.fetch),
      .rd_addr (unlink_id[AW-1:0]),
      .rd_data (rd_next)
   );

   frqs_ram #(.WIDTH(ID_W), .DEPTH(DEPTH)) u_prev_link (
      .clock   (clock),
      .wr_en   (pl_we),
      .wr_addr (pl_addr),
      .wr_data (pl_data),
      .rd_en   (cmd.fetch),
      .rd_addr (unlink_id[AW-1:0]),
      .rd_data (rd_prev)
   );

   // Decode of the held request.
   always_comb begin
      tid_ok    = ({1'b0, req_ff.thread_id} < DEPTH_LIM);
      taddr     = req_ff.thread_id[AW-1:0];
      tid_inq   = inq_ff[taddr];
      cpu_ok    = ({1'b0, req_ff.cpu_index} < CPU_LIM);
      cidx      = req_ff.cpu_index[CW-1:0];
      cur       = running_ff[cidx];
      phase_inc = phase_ff + 1'b1;
      tick_fire = (phase_inc >= interval_ff);
      sched     = cpu_ok && ((req_ff.opcode == OP_YIELD) ||
                             ((req_ff.opcode == OP_TICK) && tick_fire));
      have      = (total_ff != '0);
      if (have) begin
         nxt = '{real_thread: 1'b1, idle_thread: 1'b0, id: head_ff};
      end else begin
         nxt = '{real_thread: 1'b0, idle_thread: 1'b1, id: '0};
      end
      do_switch = sched && (nxt != cur);
      prev_ok   = ({1'b0, cur.id} < DEPTH_LIM);
      requeue   = do_switch && cur.real_thread && req_ff.prev_runnable && prev_ok &&
                  !inq_ff[cur.id[AW-1:0]];
      unlink_en = ((req_ff.opcode == OP_REMOVE) && tid_ok && tid_inq) || (sched && have);
      unlink_id = (req_ff.opcode == OP_REMOVE) ? req_ff.thread_id : head_ff;
      add_en    = (req_ff.opcode == OP_ADD) && tid_ok && !tid_inq;
      app_en    = (cmd.apply && add_en) || cmd.requeue;
      app_id    = cmd.requeue ? reid_ff : req_ff.thread_id;
   end

   assign status.requeue = requeue;

   always_comb begin
      req_in      = req_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      total_in    = total_ff;
      phase_in    = phase_ff;
      interval_in = interval_ff;
      inq_in      = inq_ff;
      running_in  = running_ff;
      reid_in     = reid_ff;
      pend_in     = pend_ff;
      rsp_in      = rsp_ff;
      strobe_in   = cmd.finish;
      nl_we       = 1'b0;
      nl_addr     = '0;
      nl_data     = '0;
      pl_we       = 1'b0;
      pl_addr     = '0;
      pl_data     = '0;

      if (csr_wr_en) begin
         interval_in = csr_wr_data;
      end
      if (cmd.accept) begin
         req_in = req_data;
      end

      if (cmd.apply) begin
         if (req_ff.opcode == OP_TICK) begin
            phase_in = tick_fire ? '0 : phase_inc;
         end
         // Unlink: the head, the tail, or splice the neighbours together.
         if (unlink_en) begin
            if (total_ff <= QCNT_W'(1)) begin
               head_in = '0;
               tail_in = '0;
            end else if (unlink_id == head_ff) begin
               head_in = rd_next;
            end else if (unlink_id == tail_ff) begin
               tail_in = rd_prev;
            end else begin
               nl_we   = 1'b1;
               nl_addr = rd_prev[AW-1:0];
               nl_data = rd_next;
               pl_we   = 1'b1;
               pl_addr = rd_next[AW-1:0];
               pl_data = rd_prev;
            end
            inq_in[unlink_id[AW-1:0]] = 1'b0;
            total_in = total_ff - 1'b1;
         end
         if (do_switch) begin
            running_in[cidx] = nxt;
         end
         reid_in              = cur.id;
         pend_in.switched     = do_switch;
         pend_in.prev_valid   = sched && cur.real_thread;
         pend_in.prev_thread  = (sched && cur.real_thread) ? cur.id : '0;
         pend_in.next_is_idle = sched && nxt.idle_thread;
         pend_in.next_thread  = (sched && nxt.real_thread) ? nxt.id : '0;
         pend_in.queue_count  = '0;
         if ((req_ff.opcode == OP_ADD) && tid_ok && tid_inq) begin
            pend_in.error_code = ERR_DUP_ADD;
         end else if ((req_ff.opcode == OP_REMOVE) && tid_ok && !tid_inq) begin
            pend_in.error_code = ERR_NOT_QUEUED;
         end else begin
            pend_in.error_code = ERR_OK;
         end
      end

      // Append at the tail: an added thread, or the preempted one.
      if (app_en) begin
         if (total_ff == '0) begin
            head_in = app_id;
         end else begin
            nl_we   = 1'b1;
            nl_addr = tail_ff[AW-1:0];
            nl_data = app_id;
            pl_we   = 1'b1;
            pl_addr = app_id[AW-1:0];
            pl_data = tail_ff;
         end
         tail_in = app_id;
         inq_in[app_id[AW-1:0]] = 1'b1;
         total_in = total_ff + 1'b1;
      end

      if (cmd.finish) begin
         rsp_in             = pend_in;
         rsp_in.queue_count = total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         total_ff    <= '0;
         phase_ff    <= '0;
         interval_ff <= TICK_INTERVAL_RESET;
         inq_ff      <= '0;
         strobe_ff   <= 1'b0;
         for (int i = 0; i < NCPU; i++) begin
            running_ff[i] <= '0;
         end
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         total_ff    <= total_in;
         phase_ff    <= phase_in;
         interval_ff <= interval_in;
         inq_ff      <= inq_in;
         strobe_ff   <= strobe_in;
         running_ff  <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      reid_ff <= reid_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

[sv/fifo_run_queue_scheduler.sv]
// Top level of the FIFO run-queue scheduler.
`timescale 1ns / 1ps
`default_nettype none

// One run queue of thread ids shared by all CPUs, held as a doubly linked list
// in two link RAMs with a membership map in flip-flops. A request (add, remove,
// timer tick or yield) is taken when start is high and busy is low; its single
// result appears on rsp_data for exactly one cycle, marked by rsp_strobe, and
// must be taken then. A request passes through a link read, then unlink or
// append, and then a requeue step when a schedule decision puts the preempted
// thread back at the tail, which needs a second pass through the link write
// ports. busy falls in the cycle the result shows, so a new request can follow
// at once. The membership map, queue pointers, tick phase and per-CPU running
// thread are cleared by reset; the link RAMs need no clearing, since a link is
// only used for a thread that is queued. tick_interval is written through
// csr_wr_en/csr_wr_data; the user must write it only while the block is idle,
// as the block itself does not enforce this. An interval of zero fires on
// every tick.

module fifo_run_queue_scheduler
   import frqs_pkg::*;
#(
   parameter int MAX_THREADS = DEF_MAX_THREADS,
   parameter int NUM_CPUS    = DEF_NUM_CPUS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire req_type           req_data,
   output logic                   rsp_strobe,
   output rsp_type                rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic [TICK_W-1:0] csr_wr_data
);

   // Only ids and CPU numbers that fit the request fields can ever be used,
   // so size the stores to that.
   localparam int THREAD_DEPTH = (MAX_THREADS < (2 ** ID_W)) ? MAX_THREADS : (2 ** ID_W);
   localparam int CPU_SLOTS    = (NUM_CPUS < (2 ** CPU_W)) ? NUM_CPUS : (2 ** CPU_W);

   cmd_type    cmd;
   status_type status;

   // Sequence each request: fetch links, apply, optional requeue.
   frqs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // Hold the queue and make the schedule decision.
   frqs_datapath #(
      .DEPTH (THREAD_DEPTH),
      .NCPU  (CPU_SLOTS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .cmd         (cmd),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .status      (status),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

[sv/frqs_checker.sv]
// Port-level checks of the run-queue scheduler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module frqs_checker
   import frqs_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_strobe,
   input wire rsp_type rsp_data
);

   // A result shows exactly when the block goes idle again.
   a_fell_busy_gives_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy fell without a result");

   a_result_while_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while busy");

   // After a request is taken, the block shows its result or is still busy.
   a_request_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 (rsp_strobe || busy))
      else $error("request made no progress");

   // A switch comes only from tick or yield, which never report an error.
   a_switch_no_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.switched) |-> (rsp_data.error_code == ERR_OK))
      else $error("switch reported with an error code");

endmodule

bind fifo_run_queue_scheduler frqs_checker u_frqs_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire

[tb/frqs_checker.sv]
// Checker of the run-queue scheduler: watches both channels, predicts each decision, compares.
`timescale 1ns / 1ps

module frqs_tb_checker
   import frqs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  req_type           req_data,
   input  logic              rsp_strobe,
   input  rsp_type           rsp_data,
   input  logic              csr_wr_en,
   input  logic [TICK_W-1:0] csr_wr_data,
   output int                fail_count,
   output int                outstanding
);

   // Own copy of the queue, the timer and what each CPU runs.
   logic [ID_W-1:0]   link_fwd  [DEF_MAX_THREADS];
   logic [ID_W-1:0]   link_back [DEF_MAX_THREADS];
   logic              is_queued [DEF_MAX_THREADS];
   logic [ID_W-1:0]   q_head;
   logic [ID_W-1:0]   q_tail;
   int                q_count;
   logic [TICK_W-1:0] tick_count;
   logic [TICK_W-1:0] tick_period;
   run_type           cpu_now   [DEF_NUM_CPUS];

   rsp_type pending_decisions[$];
   int      mismatches;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic queue_append(input logic [ID_W-1:0] t);
      if (q_count == 0) begin
         q_head = t;
         q_tail = t;
      end else begin
         link_fwd[q_tail] = t;
         link_back[t]     = q_tail;
         q_tail           = t;
      end
      is_queued[t] = 1'b1;
      q_count++;
   endtask

   task automatic queue_unlink(input logic [ID_W-1:0] t);
      logic [ID_W-1:0] p;
      logic [ID_W-1:0] n;
      if (q_count <= 1) begin
         q_head = '0;
         q_tail = '0;
      end else if (t == q_head) begin
         q_head = link_fwd[t];
      end else if (t == q_tail) begin
         q_tail = link_back[t];
      end else begin
         p = link_back[t];
         n = link_fwd[t];
         link_fwd[p]  = n;
         link_back[n] = p;
      end
      is_queued[t] = 1'b0;
      q_count--;
   endtask

   task automatic predict_decision(input req_type r, output rsp_type e);
      logic [TICK_W-1:0] bumped;
      logic              decide;
      run_type           was;
      run_type           pick;
      e      = '0;
      decide = 1'b0;
      case (r.opcode)
         OP_ADD: begin
            if (is_queued[r.thread_id]) e.error_code = ERR_DUP_ADD;
            else queue_append(r.thread_id);
         end
         OP_REMOVE: begin
            if (!is_queued[r.thread_id]) e.error_code = ERR_NOT_QUEUED;
            else queue_unlink(r.thread_id);
         end
         OP_TICK: begin
            bumped = tick_count + 1'b1;
            if (bumped >= tick_period) begin
               tick_count = '0;
               decide     = 1'b1;
            end else begin
               tick_count = bumped;
            end
         end
         default: decide = 1'b1;
      endcase

      if (decide && r.cpu_index < DEF_NUM_CPUS) begin
         was  = cpu_now[r.cpu_index];
         pick = '0;
         if (q_count > 0) begin
            pick.real_thread = 1'b1;
            pick.id          = q_head;
            queue_unlink(q_head);
         end else begin
            pick.idle_thread = 1'b1;
         end
         e.prev_valid  = was.real_thread;
         e.prev_thread = was.real_thread ? was.id : '0;
         // Same choice as now: no switch, and a popped thread stays out of the queue.
         if (pick != was) begin
            if (was.real_thread && r.prev_runnable && !is_queued[was.id])
               queue_append(was.id);
            cpu_now[r.cpu_index] = pick;
            e.switched = 1'b1;
         end
         e.next_is_idle = pick.idle_thread;
         e.next_thread  = pick.real_thread ? pick.id : '0;
      end
      e.queue_count = QCNT_W'(q_count);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         for (int i = 0; i < DEF_MAX_THREADS; i++) begin
            link_fwd[i]  = '0;
            link_back[i] = '0;
            is_queued[i] = 1'b0;
         end
         for (int c = 0; c < DEF_NUM_CPUS; c++) cpu_now[c] = '0;
         q_head      = '0;
         q_tail      = '0;
         q_count     = 0;
         tick_count  = '0;
         tick_period = TICK_INTERVAL_RESET;
         mismatches  = 0;
         pending_decisions.delete();
      end else begin
         // Check the result first: a new request may be taken in the cycle it shows.
         if (rsp_strobe) begin
            got = rsp_data;
            if (pending_decisions.size() == 0) begin
               report_mismatch("result with nothing pending", int'(got), 0);
            end else begin
               want = pending_decisions.pop_front();
               if (got.switched !== want.switched)
                  report_mismatch("switched", int'(got.switched), int'(want.switched));
               if (got.prev_valid !== want.prev_valid)
                  report_mismatch("prev_valid", int'(got.prev_valid),
                                  int'(want.prev_valid));
               if (got.prev_thread !== want.prev_thread)
                  report_mismatch("prev_thread", int'(got.prev_thread),
                                  int'(want.prev_thread));
               if (got.next_is_idle !== want.next_is_idle)
                  report_mismatch("next_is_idle", int'(got.next_is_idle),
                                  int'(want.next_is_idle));
               if (got.next_thread !== want.next_thread)
                  report_mismatch("next_thread", int'(got.next_thread),
                                  int'(want.next_thread));
               if (got.queue_count !== want.queue_count)
                  report_mismatch("queue_count", int'(got.queue_count),
                                  int'(want.queue_count));
               if (got.error_code !== want.error_code)
                  report_mismatch("error_code", int'(got.error_code),
                                  int'(want.error_code));
            end
         end
         if (start && !busy) begin
            predict_decision(req_data, want);
            pending_decisions.push_back(want);
         end
         if (csr_wr_en) tick_period = csr_wr_data;
      end
      fail_count  <= mismatches;
      outstanding <= pending_decisions.size();
   end

endmodule

[tb/tb_top.sv]
// Testbench top of the run-queue scheduler: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
   import frqs_pkg::*;

   // Longest quiet stretch of a correct run is a gap plus one request, well under this.
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASES         = 10;
   localparam int PHASE_ITEMS    = 130;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   req_type           req_data;
   logic              rsp_strobe;
   rsp_type           rsp_data;
   logic              csr_wr_en;
   logic [TICK_W-1:0] csr_wr_data;
   int                fail_count;
   int                outstanding;
   int                quiet_cycles;

   fifo_run_queue_scheduler DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   frqs_tb_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: end the run once nothing has moved on either channel for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic req_type mk_req(logic [1:0] op, int tid, int cpu, bit run);
      req_type r;
      r.opcode        = op;
      r.thread_id     = ID_W'(tid);
      r.cpu_index     = CPU_W'(cpu);
      r.prev_runnable = run;
      return r;
   endfunction

   // Draw one request from the phase's operation mix. Thread ids mostly come from a
   // small pool so that adds, removes and requeues keep hitting the same threads.
   function automatic req_type random_req(int w_add, int w_rem, int w_tick, int span);
      req_type    r;
      int         pick;
      logic [1:0] op;
      pick = $urandom_range(99);
      if (pick < w_add) op = OP_ADD;
      else if (pick < w_add + w_rem) op = OP_REMOVE;
      else if (pick < w_add + w_rem + w_tick) op = OP_TICK;
      else op = OP_YIELD;
      r.opcode        = op;
      r.thread_id     = ($urandom_range(7) == 0) ? ID_W'($urandom_range(63))
                                                 : ID_W'($urandom_range(span - 1));
      r.cpu_index     = CPU_W'($urandom_range(7));
      r.prev_runnable = ($urandom_range(3) != 0);
      return r;
   endfunction

   // Present a request and hold it until the block takes it. Leave start high on
   // return: the caller either follows at once with the next request or drops start.
   task automatic issue(input req_type r);
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Wait until every predicted result has come back, plus a short margin.
   task automatic settle();
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_interval(input logic [TICK_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int          interval;
      int          w_add;
      int          w_rem;
      int          w_tick;
      int          span;
      int          idle_pct;
      int          calm_left;

      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      calm_left   = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, at the reset interval.
      issue(mk_req(OP_YIELD, 0, 0, 1));    // empty queue: fall back to idle
      issue(mk_req(OP_YIELD, 0, 0, 1));    // idle again: no switch
      issue(mk_req(OP_TICK, 0, 1, 1));
      issue(mk_req(OP_ADD, 0, 0, 0));
      issue(mk_req(OP_ADD, 63, 7, 1));
      issue(mk_req(OP_ADD, 0, 0, 0));      // duplicate add
      issue(mk_req(OP_REMOVE, 5, 0, 0));   // remove of an absent thread
      issue(mk_req(OP_ADD, 5, 0, 0));
      issue(mk_req(OP_REMOVE, 0, 0, 0));   // unlink the head
      issue(mk_req(OP_REMOVE, 5, 0, 0));   // unlink the tail
      issue(mk_req(OP_ADD, 42, 0, 0));
      issue(mk_req(OP_ADD, 21, 0, 0));
      issue(mk_req(OP_REMOVE, 42, 0, 0));  // unlink from the middle
      issue(mk_req(OP_YIELD, 0, 7, 1));    // first real thread on this CPU
      issue(mk_req(OP_ADD, 63, 0, 0));
      issue(mk_req(OP_YIELD, 0, 7, 1));    // previous thread already queued: skip requeue
      issue(mk_req(OP_ADD, 21, 0, 0));
      issue(mk_req(OP_REMOVE, 63, 0, 0));
      issue(mk_req(OP_YIELD, 0, 7, 1));    // pops the current thread: no switch
      issue(mk_req(OP_ADD, 9, 0, 0));
      issue(mk_req(OP_YIELD, 0, 7, 1));    // runnable previous thread goes to the tail
      issue(mk_req(OP_YIELD, 0, 7, 0));    // blocked previous thread is dropped
      issue(mk_req(OP_YIELD, 0, 7, 1));    // empty queue with a runnable previous thread
      issue(mk_req(OP_REMOVE, 21, 0, 0));  // remove the only queued thread
      issue(mk_req(OP_YIELD, 63, 2, 0));
      start <= 1'b0;
      settle();

      // Random phases: each with its own interval, operation mix and idling.
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin interval = 10;    w_add = 40; w_rem = 20; w_tick = 25; span = 64; end
            1: begin interval = 1;     w_add = 40; w_rem = 20; w_tick = 25; span = 8;  end
            2: begin interval = 0;     w_add = 30; w_rem = 20; w_tick = 30; span = 16; end
            3: begin interval = 65535; w_add = 80; w_rem = 5;  w_tick = 10; span = 64; end
            4: begin interval = 3;     w_add = 20; w_rem = 30; w_tick = 20; span = 64; end
            5: begin interval = 2;     w_add = 45; w_rem = 15; w_tick = 20; span = 8;  end
            6: begin interval = 65535; w_add = 85; w_rem = 5;  w_tick = 5;  span = 64; end
            7: begin interval = 7;     w_add = 10; w_rem = 35; w_tick = 20; span = 64; end
            8: begin interval = 1;     w_add = 40; w_rem = 20; w_tick = 25; span = 64; end
            default: begin
               interval = 5; w_add = 35; w_rem = 25; w_tick = 20; span = 4;
            end
         endcase
         // Cycle the sender through no idling, heavy idling and light idling.
         case (ph % 3)
            0:       idle_pct = 0;
            1:       idle_pct = 57;
            default: idle_pct = 22;
         endcase
         write_interval(TICK_W'(interval));

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            issue(random_req(w_add, w_rem, w_tick, span));
            // Now and then hold a stretch with no idling at all.
            if (calm_left > 0) calm_left--;
            else if ($urandom_range(39) == 0) calm_left = $urandom_range(40, 10);
            if (calm_left == 0 && $urandom_range(99) < idle_pct) begin
               start <= 1'b0;
               repeat ($urandom_range(6, 1)) @(posedge clock);
            end
         end
         start <= 1'b0;
         settle();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
